// File: hdl/sbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared constants and control/status bundles for the Stern-Brocot
// fraction approximator.
// ----------------------------------------------------------------------------
package sbf_pkg;

   localparam int FRAC_BITS_DEF = 32;
   localparam int DEN_BITS_DEF  = 16;

   // CSR map
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int LIMIT_W    = 16;
   localparam logic CSR_IDX_MAX_DEN_SUM = 1'b0;
   localparam logic [LIMIT_W-1:0] MAX_DEN_SUM_RESET = 16'd1000;

   // top -> walk core
   typedef struct packed {
      logic start;   // transaction accepted, load fraction
      logic take;    // result moved to output register
   } sbf_ctrl_type;

   // walk core -> top
   typedef struct packed {
      logic busy;    // not able to take a new fraction
      logic done;    // result fields valid
   } sbf_status_type;

endpackage
`default_nettype wire

// File: hdl/sbf_walk_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbf_walk_core
// Mediant walk sequencer with residual subtractor, then a bit-serial
// weighing of the two residuals to pick the nearer bound.
// ----------------------------------------------------------------------------
module sbf_walk_core #(
   parameter int FRAC_BITS = sbf_pkg::FRAC_BITS_DEF,
   parameter int DEN_BITS  = sbf_pkg::DEN_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sbf_pkg::sbf_ctrl_type       ctrl,
   input  wire logic [FRAC_BITS-1:0]        fraction,
   input  wire logic [sbf_pkg::LIMIT_W-1:0] max_den_sum,
   output sbf_pkg::sbf_status_type          status,
   output logic [DEN_BITS-1:0]              numerator,
   output logic [DEN_BITS-1:0]              denominator,
   output logic                             carry_one
);

   localparam int E_W   = FRAC_BITS + 1;
   localparam int ACC_W = FRAC_BITS + DEN_BITS + 2;
   localparam int CNT_W = $clog2(DEN_BITS);
   localparam int SUM_W = DEN_BITS + 1;
   localparam int CMP_W = (SUM_W > sbf_pkg::LIMIT_W) ? SUM_W : sbf_pkg::LIMIT_W;

   localparam logic [E_W-1:0]   E_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CNT_W-1:0] BIT_TOP = CNT_W'(DEN_BITS - 1);
   localparam logic [SUM_W-1:0] DEN_MAX = {1'b0, {DEN_BITS{1'b1}}};
   localparam logic [DEN_BITS-1:0] DEN_ONE = DEN_BITS'(1);

   typedef enum logic [1:0] {
      IDLE,
      WALK,
      WEIGH,
      DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [DEN_BITS-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [E_W-1:0]      el_ff, el_in, eu_ff, eu_in;   // y*b - a, c - y*d (scaled)
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [CNT_W-1:0]    bit_ff, bit_in;

   logic [SUM_W-1:0]    sum_bd;
   logic                stop;
   logic [ACC_W-1:0]    el_term, eu_term;
   logic                pick_upper;
   logic [DEN_BITS-1:0] num_sel, den_sel;

   assign sum_bd = {1'b0, b_ff} + {1'b0, d_ff};
   assign stop   = (CMP_W'(sum_bd) >= CMP_W'(max_den_sum)) || (sum_bd >= DEN_MAX);

   assign el_term = d_ff[bit_ff] ? ACC_W'(el_ff) : '0;
   assign eu_term = b_ff[bit_ff] ? ACC_W'(eu_ff) : '0;

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      el_in    = el_ff;
      eu_in    = eu_ff;
      acc_in   = acc_ff;
      bit_in   = bit_ff;
      unique case (state_ff)
         IDLE: begin
            if (ctrl.start) begin
               a_in     = '0;
               b_in     = DEN_ONE;
               c_in     = DEN_ONE;
               d_in     = DEN_ONE;
               el_in    = {1'b0, fraction};
               eu_in    = E_ONE - {1'b0, fraction};
               state_in = WALK;
            end
         end
         WALK: begin
            if (stop) begin
               acc_in   = '0;
               bit_in   = BIT_TOP;
               state_in = WEIGH;
            end else if (eu_ff <= el_ff) begin
               // mediant at or below y: raise lower bound
               a_in  = a_ff + c_ff;
               b_in  = b_ff + d_ff;
               el_in = el_ff - eu_ff;
            end else begin
               c_in  = c_ff + a_ff;
               d_in  = d_ff + b_ff;
               eu_in = eu_ff - el_ff;
            end
         end
         WEIGH: begin
            // acc accumulates el*d - eu*b, MSB first
            acc_in = {acc_ff[ACC_W-2:0], 1'b0} + el_term - eu_term;
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = DONE;
            end
         end
         DONE: begin
            if (ctrl.take) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      el_ff  <= el_in;
      eu_ff  <= eu_in;
      acc_ff <= acc_in;
      bit_ff <= bit_in;
   end

   // upper strictly nearer when el*d > eu*b; tie keeps lower
   assign pick_upper = !acc_ff[ACC_W-1] && (acc_ff != '0);
   assign num_sel    = pick_upper ? c_ff : a_ff;
   assign den_sel    = pick_upper ? d_ff : b_ff;

   assign carry_one   = (num_sel == den_sel);
   assign numerator   = carry_one ? '0 : num_sel;
   assign denominator = carry_one ? DEN_ONE : den_sel;

   assign status.busy = (state_ff != IDLE);
   assign status.done = (state_ff == DONE);

   // upper residual is never zero since y < 1
   a_eu_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == WALK) |-> (eu_ff != '0))
      else $error("upper residual reached zero");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == WALK) |-> ((b_ff != '0) && (d_ff != '0)))
      else $error("zero denominator in walk");

   a_weigh_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == WEIGH) && (bit_ff == '0)) |=> (state_ff == DONE))
      else $error("weighing did not finish");

   a_start_walk: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == IDLE) && ctrl.start) |=> (state_ff == WALK))
      else $error("start did not enter walk");

endmodule
`default_nettype wire

// File: hdl/stern_brocot_fraction_approximator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stern_brocot_fraction_approximator
// Best rational approximation of an unsigned Q0.FRAC_BITS fraction with
// bounded denominators, by walking the Stern-Brocot tree.
// ----------------------------------------------------------------------------
// One fraction is processed at a time. After a req transaction the block
// walks the tree one mediant per cycle until lower plus upper denominator
// reaches max_den_sum (clamped to 2^DEN_BITS-1), then weighs the two
// bounds bit-serially. The walk takes at most max_den_sum - 2 mediant
// steps, max_den_sum resetting to 1000; fractions close to 0 or 1 take
// the most steps. Each step uses the residual subtractor: each bound
// carries its scaled distance to y, and a mediant test is one compare,
// the update one subtract. req_stall stays high while the walk runs. A
// finished result moves to the rsp output register, and the next
// fraction may be taken while that result waits out rsp_stall. Ties
// between bounds go to the lower one. A result of 1/1 comes out as 0/1
// with carry_one set. max_den_sum sits at CSR byte address 0 and must
// only be written while the block is idle.
// ----------------------------------------------------------------------------
module stern_brocot_fraction_approximator #(
   parameter int FRAC_BITS = sbf_pkg::FRAC_BITS_DEF,
   parameter int DEN_BITS  = sbf_pkg::DEN_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [FRAC_BITS-1:0]           req_fraction,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [DEN_BITS-1:0]                 rsp_numerator,
   output logic [DEN_BITS-1:0]                 rsp_denominator,
   output logic                                rsp_carry_one,
   // CSR port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [sbf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [sbf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sbf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   sbf_pkg::sbf_ctrl_type   ctrl;
   sbf_pkg::sbf_status_type status;

   logic [sbf_pkg::LIMIT_W-1:0] max_den_sum_ff, max_den_sum_in;
   logic                        csr_hit;

   logic [DEN_BITS-1:0] core_numerator, core_denominator;
   logic                core_carry_one;
   logic                load;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DEN_BITS-1:0] rsp_numerator_ff, rsp_numerator_in;
   logic [DEN_BITS-1:0] rsp_denominator_ff, rsp_denominator_in;
   logic                rsp_carry_one_ff, rsp_carry_one_in;

   // ---- CSR: single register, index taken from paddr[2]
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == sbf_pkg::CSR_IDX_MAX_DEN_SUM);

   always_comb begin
      max_den_sum_in = max_den_sum_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         max_den_sum_in = csr_pwdata[sbf_pkg::LIMIT_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? sbf_pkg::CSR_DATA_W'(max_den_sum_ff) : '0;

   // ---- request side: core takes a transaction only when idle
   assign req_stall  = status.busy;
   assign ctrl.start = req_valid && !status.busy;

   // ---- result hand-off into the output register
   assign load      = status.done && (!rsp_valid_ff || !rsp_stall);
   assign ctrl.take = load;

   always_comb begin
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_numerator_in   = rsp_numerator_ff;
      rsp_denominator_in = rsp_denominator_ff;
      rsp_carry_one_in   = rsp_carry_one_ff;
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_numerator_in   = core_numerator;
         rsp_denominator_in = core_denominator;
         rsp_carry_one_in   = core_carry_one;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_den_sum_ff <= sbf_pkg::MAX_DEN_SUM_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_den_sum_ff <= max_den_sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_numerator_ff   <= rsp_numerator_in;
      rsp_denominator_ff <= rsp_denominator_in;
      rsp_carry_one_ff   <= rsp_carry_one_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_numerator   = rsp_numerator_ff;
   assign rsp_denominator = rsp_denominator_ff;
   assign rsp_carry_one   = rsp_carry_one_ff;

   sbf_walk_core #(
      .FRAC_BITS (FRAC_BITS),
      .DEN_BITS  (DEN_BITS)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .fraction    (req_fraction),
      .max_den_sum (max_den_sum_ff),
      .status      (status),
      .numerator   (core_numerator),
      .denominator (core_denominator),
      .carry_one   (core_carry_one)
   );

   // ---- checks on the hand-off
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !load)
      else $error("pending response overwritten");

   a_load_empties_core: assert property (@(posedge clock) disable iff (reset)
      load |=> !status.done)
      else $error("core still done after hand-off");

   a_no_start_while_done: assert property (@(posedge clock) disable iff (reset)
      status.done |-> !ctrl.start)
      else $error("start while result pending in core");

endmodule
`default_nettype wire
